[design/scalar_kalman_filter_top_defines.svh]
// Assertion macros for the scalar Kalman filter
`ifndef SCALAR_KALMAN_FILTER_TOP_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_TOP_DEFINES_SVH

// same-cycle implication
`define SKF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SKF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/skf_pkg.sv]
package skf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int GAIN_BITS = 16;
	localparam int GAIN_W    = GAIN_BITS + 1;
	localparam int QUO_BITS  = GAIN_W;
	localparam int P1_W      = DATA_W + 1;
	localparam int DEN_W     = DATA_W + 1;
	localparam int NUM_W     = DATA_W + GAIN_BITS + 1;
	localparam int PROD_W    = DATA_W + GAIN_W;
	localparam int CNT_W     = $clog2(QUO_BITS + 1);
	localparam int CFG_IDX_W = 8;

	localparam logic [GAIN_W-1:0] GAIN_ONE   = {1'b1, {GAIN_BITS{1'b0}}};
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_BITS - 1);
	localparam logic [DATA_W-1:0] ONE_Q      = DATA_W'(1) << FRAC_BITS;
	localparam logic [DATA_W-1:0] Q_RESET    = DATA_W'(((1 << FRAC_BITS) + 50) / 100);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROC_NOISE,
		REG_MEAS_NOISE,
		REG_INIT_EST,
		REG_INIT_COV
	} skf_reg_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_ERR,
		ST_HALT
	} skf_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_LOAD,
		S_DIV,
		S_MUL_X,
		S_MUL_P,
		S_UPD,
		S_OUT
	} skf_state_t;

	typedef struct packed {
		logic [DATA_W-1:0]        q;
		logic [DATA_W-1:0]        r;
		logic signed [DATA_W-1:0] init_est;
		logic [DATA_W-1:0]        init_cov;
	} skf_cfg_t;

endpackage

[design/skf_cfg_regs.sv]
module skf_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [skf_pkg::DATA_W-1:0]    cfg_data,
	output skf_pkg::skf_cfg_t             cfg
);
	import skf_pkg::*;

	skf_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.q        <= Q_RESET;
			cfg_q.r        <= ONE_Q;
			cfg_q.init_est <= '0;
			cfg_q.init_cov <= ONE_Q;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROC_NOISE: cfg_q.q        <= cfg_data;
				REG_MEAS_NOISE: cfg_q.r        <= cfg_data;
				REG_INIT_EST:   cfg_q.init_est <= cfg_data;
				REG_INIT_COV:   cfg_q.init_cov <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/skf_divider.sv]
module skf_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [skf_pkg::DATA_W-1:0]   p1,
	input  logic [skf_pkg::DEN_W-1:0]    den,
	output logic [skf_pkg::QUO_BITS-1:0] quotient,
	output logic                         done
);
	import skf_pkg::*;

	// restoring divide of (p1 << 16) + den/2 by den, one quotient bit per cycle
	logic [NUM_W-1:0]    num;
	logic [DEN_W-1:0]    den_q;
	logic [DEN_W-1:0]    rem_q;
	logic [QUO_BITS-1:0] low_q;
	logic [QUO_BITS-1:0] quo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                done_q;
	logic [DEN_W:0]      trial;
	logic                fits;

	assign num   = NUM_W'({p1, {GAIN_BITS{1'b0}}}) + NUM_W'(den[DEN_W-1:1]);
	assign trial = {rem_q, low_q[QUO_BITS-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start)
				cnt_q <= CNT_W'(QUO_BITS);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= {1'b0, num[NUM_W-1:QUO_BITS]};
			low_q <= num[QUO_BITS-1:0];
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			low_q <= {low_q[QUO_BITS-2:0], 1'b0};
			quo_q <= {quo_q[QUO_BITS-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

[design/scalar_kalman_filter_top.sv]
// One-dimensional Kalman filter on Q16.16 samples. A transfer occupies the block
// until its result is loaded into the output register, which waits on out_ready
// while it holds an unaccepted result. A restart, a sample taken while halted or
// a sample with an error goes straight to the output. The gain is formed by a
// 17-step restoring divider; both products (gain times innovation, one minus gain
// times covariance) go through one shared 32x17 multiplier. An overflow or a zero
// denominator halts the filter until a restart transfer reloads estimate and covariance from the initial registers.
`include "scalar_kalman_filter_top_defines.svh"

module scalar_kalman_filter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [skf_pkg::DATA_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic signed [31:0]            measurement,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            estimate,
	output logic [16:0]                   gain,
	output logic [1:0]                    status
);
	import skf_pkg::*;

	skf_cfg_t cfg;

	skf_state_t state_q, state_d;

	logic                     op_q;
	logic [DATA_W-1:0]        meas_q;
	logic [DATA_W-1:0]        est_q;
	logic [DATA_W-1:0]        cov_q;
	logic                     halted_q;
	logic [DATA_W-1:0]        p1_q;
	logic [DEN_W-1:0]         den_q;
	logic [DATA_W:0]          innov_q;
	logic [DATA_W-1:0]        mag_q;
	logic [GAIN_W-1:0]        gain_q;
	logic [DATA_W-1:0]        corr_mag_q;
	logic [PROD_W-1:0]        prod_q;
	logic [DATA_W-1:0]        res_est_q;
	logic [GAIN_W-1:0]        res_gain_q;
	skf_status_t              res_status_q;
	logic                     out_valid_q;
	logic [DATA_W-1:0]        out_estimate_q;
	logic [GAIN_W-1:0]        out_gain_q;
	skf_status_t              out_status_q;

	logic [P1_W-1:0]          p1_c;
	logic [DEN_W:0]           den_c;
	logic                     err_c;
	logic                     div_start;
	logic [QUO_BITS-1:0]      div_quo;
	logic                     div_done;
	logic [GAIN_W-1:0]        gain_c;
	logic [DATA_W-1:0]        mul_a;
	logic [GAIN_W-1:0]        mul_b;
	logic [PROD_W-1:0]        prod_rnd;
	logic [DATA_W+1:0]        corr_c;
	logic [DATA_W+1:0]        nx_c;
	logic                     nx_ovf;
	logic                     out_load;

	skf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	skf_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.p1       (p1_q),
		.den      (den_q),
		.quotient (div_quo),
		.done     (div_done)
	);

	assign p1_c   = {1'b0, cov_q} + {1'b0, cfg.q};
	assign den_c  = {1'b0, p1_c} + {2'b0, cfg.r};
	assign err_c  = p1_c[DATA_W] || (den_c == '0);
	assign gain_c = (div_quo > GAIN_ONE) ? GAIN_ONE : div_quo;

	assign prod_rnd = prod_q + ROUND_HALF;
	assign corr_c   = innov_q[DATA_W] ? (DATA_W+2)'(-{2'b0, corr_mag_q})
	                                  : {2'b0, corr_mag_q};
	assign nx_c     = {{2{est_q[DATA_W-1]}}, est_q} + corr_c;
	assign nx_ovf   = !((nx_c[DATA_W+1:DATA_W-1] == 3'b000) ||
	                    (nx_c[DATA_W+1:DATA_W-1] == 3'b111));
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_d = S_PREP;
			S_PREP:  state_d = (op_q || halted_q || err_c) ? S_OUT : S_LOAD;
			S_LOAD:  state_d = S_DIV;
			S_DIV:   if (div_done) state_d = S_MUL_X;
			S_MUL_X: state_d = S_MUL_P;
			S_MUL_P: state_d = S_UPD;
			S_UPD:   state_d = S_OUT;
			S_OUT:   if (!out_valid_q || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs and shared multiplier operands
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		mul_a     = mag_q;
		mul_b     = gain_c;
		case (state_q)
			S_IDLE:  in_ready = 1'b1;
			S_LOAD:  div_start = 1'b1;
			S_MUL_X: begin
				mul_a = mag_q;
				mul_b = gain_c;
			end
			S_MUL_P: begin
				mul_a = p1_q;
				mul_b = GAIN_ONE - gain_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q    <= '0;
			cov_q    <= '0;
			halted_q <= 1'b0;
		end else if (state_q == S_PREP) begin
			if (op_q) begin
				est_q    <= cfg.init_est;
				cov_q    <= cfg.init_cov;
				halted_q <= 1'b0;
			end else if (!halted_q && err_c) begin
				halted_q <= 1'b1;
			end
		end else if (state_q == S_UPD) begin
			if (nx_ovf) begin
				halted_q <= 1'b1;
			end else begin
				est_q <= nx_c[DATA_W-1:0];
				cov_q <= prod_rnd[GAIN_BITS+DATA_W-1:GAIN_BITS];
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		if (in_valid && in_ready) begin
			op_q   <= op;
			meas_q <= measurement;
		end
		case (state_q)
			S_PREP: begin
				p1_q    <= p1_c[DATA_W-1:0];
				den_q   <= den_c[DEN_W-1:0];
				innov_q <= {meas_q[DATA_W-1], meas_q} - {est_q[DATA_W-1], est_q};
				res_gain_q <= '0;
				if (op_q) begin
					res_est_q    <= cfg.init_est;
					res_status_q <= ST_OK;
				end else if (halted_q) begin
					res_est_q    <= est_q;
					res_status_q <= ST_HALT;
				end else begin
					res_est_q    <= est_q;
					res_status_q <= ST_ERR;
				end
			end
			S_LOAD: mag_q <= innov_q[DATA_W] ? DATA_W'(-innov_q) : innov_q[DATA_W-1:0];
			S_MUL_X: gain_q <= gain_c;
			S_MUL_P: corr_mag_q <= prod_rnd[GAIN_BITS+DATA_W-1:GAIN_BITS];
			S_UPD: begin
				if (nx_ovf) begin
					res_est_q    <= est_q;
					res_gain_q   <= '0;
					res_status_q <= ST_ERR;
				end else begin
					res_est_q    <= nx_c[DATA_W-1:0];
					res_gain_q   <= gain_q;
					res_status_q <= ST_OK;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_estimate_q <= res_est_q;
			out_gain_q     <= res_gain_q;
			out_status_q   <= res_status_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign estimate  = out_estimate_q;
	assign gain      = out_gain_q;
	assign status    = out_status_q;

	`SKF_ASSERT_IMP(a_halt_reports_err, clk, arst_n, $rose(halted_q), (state_q == S_OUT) && (res_status_q == ST_ERR), "halt set without an error result")
	`SKF_ASSERT_IMP(a_gain_range, clk, arst_n, out_valid_q, (out_gain_q <= GAIN_ONE) && ((out_gain_q == '0) || (out_status_q == ST_OK)), "bad gain on result")
	`SKF_ASSERT_IMP(a_div_done_in_div, clk, arst_n, div_done, state_q == S_DIV, "divider finished outside divide phase")
	`SKF_ASSERT_NXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready, "second transfer while busy")

endmodule

[tb/skf_checker.sv]
module skf_checker
	import skf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 op,
	input  logic [DATA_W-1:0]    measurement,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [DATA_W-1:0]    estimate,
	input  logic [GAIN_W-1:0]    gain,
	input  logic [1:0]           status,
	output int unsigned          mismatches,
	output int unsigned          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [DATA_W-1:0] estimate;
		logic [GAIN_W-1:0] gain;
		skf_status_t       status;
	} kalman_out_t;

	localparam logic signed [63:0] EST_MAX = 64'sh7FFF_FFFF;
	localparam logic signed [63:0] EST_MIN = -64'sh8000_0000;

	skf_cfg_t          regs;
	logic [DATA_W-1:0] est_q;
	logic [DATA_W-1:0] cov_q;
	logic              halted;
	kalman_out_t       expected_q[$];

	function automatic kalman_out_t filter_step(logic op_i, logic [DATA_W-1:0] meas_i);
		logic [63:0]        p1;
		logic [63:0]        den;
		logic [63:0]        k;
		logic [63:0]        mag;
		logic [63:0]        corr_mag;
		logic [63:0]        np;
		logic signed [63:0] innov;
		logic signed [63:0] corr;
		logic signed [63:0] nx;
		kalman_out_t        res;
		res.estimate = est_q;
		res.gain     = '0;
		res.status   = ST_OK;
		if (op_i) begin
			est_q        = regs.init_est;
			cov_q        = regs.init_cov;
			halted       = 1'b0;
			res.estimate = est_q;
			return res;
		end
		if (halted) begin
			res.status = ST_HALT;
			return res;
		end
		p1  = {32'b0, cov_q} + {32'b0, regs.q};
		den = p1 + {32'b0, regs.r};
		if (p1 > 64'hFFFF_FFFF || den == 0) begin
			halted     = 1'b1;
			res.status = ST_ERR;
			return res;
		end
		k = ((p1 << GAIN_BITS) + (den >> 1)) / den;
		if (k > 64'(GAIN_ONE))
			k = 64'(GAIN_ONE);
		innov    = $signed({{32{meas_i[31]}}, meas_i}) - $signed({{32{est_q[31]}}, est_q});
		mag      = innov[63] ? -innov : innov;
		corr_mag = (mag * k + (64'd1 << (GAIN_BITS - 1))) >> GAIN_BITS;
		corr     = innov[63] ? -$signed(corr_mag) : $signed(corr_mag);
		nx       = $signed({{32{est_q[31]}}, est_q}) + corr;
		if (nx > EST_MAX || nx < EST_MIN) begin
			halted     = 1'b1;
			res.status = ST_ERR;
			return res;
		end
		np    = ((64'(GAIN_ONE) - k) * p1 + (64'd1 << (GAIN_BITS - 1))) >> GAIN_BITS;
		est_q = nx[DATA_W-1:0];
		cov_q = np[DATA_W-1:0];
		res.estimate = est_q;
		res.gain     = k[GAIN_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got_v, logic [63:0] want_v);
		$display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got_v, want_v);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		kalman_out_t want;
		if (!arst_n) begin
			regs.q        = Q_RESET;
			regs.r        = ONE_Q;
			regs.init_est = '0;
			regs.init_cov = ONE_Q;
			est_q         = '0;
			cov_q         = '0;
			halted        = 1'b0;
			expected_q.delete();
			pending       = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PROC_NOISE: regs.q        = cfg_data;
					REG_MEAS_NOISE: regs.r        = cfg_data;
					REG_INIT_EST:   regs.init_est = cfg_data;
					REG_INIT_COV:   regs.init_cov = cfg_data;
					default: ;
				endcase
			end
			// result transfer first: a result can never belong to an item taken on the same edge
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result, estimate", estimate, '0);
				end else begin
					want = expected_q.pop_front();
					if (estimate !== want.estimate)
						report_mismatch("estimate", estimate, want.estimate);
					if (gain !== want.gain)
						report_mismatch("gain", gain, want.gain);
					if (status !== want.status)
						report_mismatch("status", status, want.status);
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(filter_step(op, measurement));
			pending = expected_q.size();
		end
	end

endmodule

[tb/scalar_kalman_filter_top_test.sv]
module scalar_kalman_filter_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import skf_pkg::*;

	localparam logic [DATA_W-1:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] NEG_MAX = 32'h8000_0000;
	localparam logic [DATA_W-1:0] ALL_ONE = 32'hFFFF_FFFF;
	localparam logic              OP_FILTER  = 1'b0;
	localparam logic              OP_RESTART = 1'b1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 op = 1'b0;
	logic signed [31:0]   measurement = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [31:0]   estimate;
	logic [16:0]          gain;
	logic [1:0]           status;
	int unsigned          mismatches;
	int unsigned          pending;
	bit                   quiet = 1'b0;
	bit                   long_hold = 1'b0;

	scalar_kalman_filter_top dut (.*);

	skf_checker chk (.*);

	always #1 clk = ~clk;

	initial begin
		#1_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send_sample(logic op_i, logic [DATA_W-1:0] meas_i);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= op_i;
		measurement <= meas_i;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(logic [DATA_W-1:0] q, r, x0, p0);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PROC_NOISE;
		cfg_data  <= q;
		@(posedge clk);
		cfg_index <= REG_MEAS_NOISE;
		cfg_data  <= r;
		@(posedge clk);
		cfg_index <= REG_INIT_EST;
		cfg_data  <= x0;
		@(posedge clk);
		cfg_index <= REG_INIT_COV;
		cfg_data  <= p0;
		@(posedge clk);
		// unmapped index, must be ignored
		cfg_index <= CFG_IDX_W'($urandom_range(int'(REG_INIT_COV) + 1, 2 ** CFG_IDX_W - 1));
		cfg_data  <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic rand_config();
		logic [DATA_W-1:0] v[4];
		int unsigned kind;
		kind = $urandom_range(0, 9);
		if (kind < 2) begin
			foreach (v[i]) v[i] = $urandom;
		end else if (kind == 2) begin
			v[0] = $urandom_range(0, 3);
			v[1] = $urandom_range(0, 3);
			v[2] = $urandom;
			v[3] = $urandom_range(0, 3);
		end else begin
			v[0] = $urandom_range(0, 1 << 20);
			v[1] = $urandom_range(1, 1 << 24);
			v[2] = $urandom_range(0, 1 << 24) - (1 << 23);
			v[3] = $urandom_range(0, 1 << 24);
		end
		write_regs(v[0], v[1], v[2], v[3]);
	endtask

	function automatic logic [DATA_W-1:0] rand_meas();
		case ($urandom_range(0, 9))
			0, 1: begin
				case ($urandom_range(0, 3))
					0: return POS_MAX;
					1: return NEG_MAX;
					2: return '0;
					default: return ALL_ONE;
				endcase
			end
			2, 3, 4: return $urandom;
			default: return $urandom_range(0, 1 << 22) - (1 << 21);
		endcase
	endfunction

	// receiver: random stalls, occasional long hold-off so the block backs up
	initial begin
		int unsigned stall;
		forever begin
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
			end
			stall = quiet ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, first sample before any restart
		send_sample(OP_FILTER, ONE_Q);
		send_sample(OP_RESTART, $urandom);
		send_sample(OP_FILTER, POS_MAX);
		send_sample(OP_FILTER, NEG_MAX);
		send_sample(OP_FILTER, '0);
		send_sample(OP_FILTER, ALL_ONE);
		send_sample(OP_FILTER, 32'd1);
		send_sample(OP_RESTART, $urandom);
		settle();

		// unit gain, then covariance collapses to zero: zero denominator
		write_regs('0, '0, POS_MAX, ONE_Q);
		send_sample(OP_RESTART, $urandom);
		send_sample(OP_FILTER, NEG_MAX);
		send_sample(OP_FILTER, POS_MAX);
		send_sample(OP_FILTER, $urandom);
		send_sample(OP_FILTER, $urandom);
		send_sample(OP_RESTART, $urandom);
		send_sample(OP_FILTER, '0);
		settle();

		// covariance overflow, halted, restart while halted and while running
		write_regs(ALL_ONE, ALL_ONE, NEG_MAX, ALL_ONE);
		send_sample(OP_RESTART, $urandom);
		send_sample(OP_FILTER, POS_MAX);
		send_sample(OP_FILTER, '0);
		send_sample(OP_RESTART, $urandom);
		send_sample(OP_RESTART, $urandom);
		settle();

		// vanishing gain, widest innovation
		write_regs(32'd1, ALL_ONE, ALL_ONE, '0);
		send_sample(OP_RESTART, $urandom);
		send_sample(OP_FILTER, POS_MAX);
		send_sample(OP_FILTER, NEG_MAX);
		settle();

		for (int ph = 0; ph < 13; ph++) begin
			rand_config();
			if ($urandom_range(0, 3) != 0)
				send_sample(OP_RESTART, $urandom);
			if (ph == 2 || ph == 8)
				long_hold = 1'b1;
			for (int i = 0; i < 100; i++) begin
				if (i % 25 == 0)
					quiet = ($urandom_range(0, 3) == 0);
				send_sample(($urandom_range(0, 15) == 0) ? OP_RESTART : OP_FILTER, rand_meas());
			end
			settle();
		end

		for (int n = 0; n < 5000 && pending != 0; n++)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
